// File: rtl/rmi_pkg.sv
`timescale 1ns / 1ps
package rmi_pkg;
	localparam int NUM_PROCS = 16;
	localparam int ID_BITS = $clog2(NUM_PROCS);
	localparam int HANDLE_BITS = 32;
	localparam int QUEUE_DEPTH = 2;

	typedef logic [ID_BITS-1:0] id_t;
	typedef logic [HANDLE_BITS-1:0] handle_t;

	typedef enum logic [1:0] {
		OUT_DELIVERED = 2'd0,
		OUT_BLOCKED = 2'd1,
		OUT_ERROR = 2'd2
	} outcome_t;

	typedef enum logic [1:0] {
		ST_NORMAL = 2'd0,
		ST_SENDING = 2'd1,
		ST_RECEIVING = 2'd2
	} pstat_t;

	typedef enum logic [1:0] {
		CMD_ERROR = 2'd0,
		CMD_SEND = 2'd1,
		CMD_RECV = 2'd2
	} cmd_t;

	typedef struct packed {
		logic req_type;
		id_t caller_id;
		id_t peer_id;
		logic peer_any;
		handle_t buffer_handle;
	} req_t;

	typedef struct packed {
		logic [1:0] outcome;
		handle_t copy_from;
		handle_t copy_to;
		id_t sender_id;
		id_t receiver_id;
		logic woken_valid;
		id_t woken_id;
	} rsp_t;

	typedef struct packed {
		cmd_t cmd;
		id_t caller;
		id_t peer;
		logic any;
		handle_t handle;
	} op_t;
endpackage

// File: rtl/rmi_front.sv
`timescale 1ns / 1ps
module rmi_front import rmi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input req_t req,
	output logic op_valid,
	output op_t op,
	input logic op_pop
);
	localparam int CB = $clog2(QUEUE_DEPTH+1);
	localparam int PB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	op_t mem_q [QUEUE_DEPTH];
	logic [PB-1:0] wp_q, rp_q;
	logic [CB-1:0] cnt_q;
	op_t cls;
	logic wr, rd;

	// classify: only self-send is an error for a 16-process id range
	always_comb begin
		cls.caller = req.caller_id;
		cls.peer = req.peer_id;
		cls.any = req.peer_any;
		cls.handle = req.buffer_handle;
		if (!req.req_type && req.caller_id == req.peer_id) cls.cmd = CMD_ERROR;
		else if (req.req_type) cls.cmd = CMD_RECV;
		else cls.cmd = CMD_SEND;
	end

	assign full = (cnt_q == CB'(QUEUE_DEPTH));
	assign op_valid = (cnt_q != '0);
	assign op = mem_q[rp_q];
	assign wr = push && !full;
	assign rd = op_pop && op_valid;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == PB'(QUEUE_DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == PB'(QUEUE_DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + CB'(wr) - CB'(rd);
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CB'(QUEUE_DEPTH)) else $error("queue overflow");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd |=> full) else $error("full dropped");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!op_valid && !wr |=> !op_valid) else $error("item from nowhere");
endmodule

// File: rtl/rmi_back.sv
`timescale 1ns / 1ps
module rmi_back import rmi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic op_valid,
	input op_t op,
	output logic op_pop,
	output logic empty,
	input logic pop,
	output rsp_t rsp
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_WALK = 4'b0100,
		S_DONE = 4'b1000
	} st_t;

	st_t st_q;
	op_t op_q;
	pstat_t stat_q [NUM_PROCS];
	logic [ID_BITS:0] want_q [NUM_PROCS];
	logic [ID_BITS:0] tgt_q [NUM_PROCS];
	logic [ID_BITS:0] nxt_q [NUM_PROCS];
	logic [ID_BITS:0] head_q [NUM_PROCS];
	logic [ID_BITS:0] tail_q [NUM_PROCS];
	handle_t buf_q [NUM_PROCS];
	logic [ID_BITS:0] prev_q, cur_q, s_q;
	rsp_t res_q;
	logic res_v_q;

	localparam logic [ID_BITS:0] NONE = (ID_BITS+1)'(NUM_PROCS);
	localparam logic [ID_BITS:0] ANY = (ID_BITS+1)'(NUM_PROCS+1);

	assign empty = !res_v_q;
	assign rsp = res_q;
	assign op_pop = (st_q == S_IDLE) && op_valid && !res_v_q;

	always_ff @(posedge clk) begin
		if (op_pop) op_q <= op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res_v_q <= 1'b0;
			res_q <= '0;
			prev_q <= '0;
			cur_q <= '0;
			s_q <= '0;
			for (int i = 0; i < NUM_PROCS; i++) begin
				stat_q[i] <= ST_NORMAL;
				want_q[i] <= NONE;
				tgt_q[i] <= NONE;
				nxt_q[i] <= NONE;
				head_q[i] <= NONE;
				tail_q[i] <= NONE;
			end
		end else begin
			if (pop && res_v_q) res_v_q <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (op_pop) st_q <= S_EXEC;
				end
				S_EXEC: begin
					res_q <= '0;
					res_q.outcome <= OUT_BLOCKED;
					st_q <= S_DONE;
					if (op_q.cmd == CMD_ERROR) begin
						res_q.outcome <= OUT_ERROR;
					end else if (stat_q[op_q.caller] != ST_NORMAL) begin
						res_q.outcome <= OUT_BLOCKED;
					end else if (op_q.cmd == CMD_SEND) begin
						buf_q[op_q.caller] <= op_q.handle;
						if (stat_q[op_q.peer] == ST_RECEIVING &&
								(want_q[op_q.peer] == {1'b0, op_q.caller} ||
								want_q[op_q.peer] == ANY)) begin
							res_q.outcome <= OUT_DELIVERED;
							res_q.copy_from <= op_q.handle;
							res_q.copy_to <= buf_q[op_q.peer];
							res_q.sender_id <= op_q.caller;
							res_q.receiver_id <= op_q.peer;
							res_q.woken_valid <= 1'b1;
							res_q.woken_id <= op_q.peer;
							want_q[op_q.peer] <= NONE;
							stat_q[op_q.peer] <= ST_NORMAL;
						end else begin
							tgt_q[op_q.caller] <= {1'b0, op_q.peer};
							stat_q[op_q.caller] <= ST_SENDING;
							nxt_q[op_q.caller] <= NONE;
							if (tail_q[op_q.peer] != NONE)
								nxt_q[tail_q[op_q.peer][ID_BITS-1:0]] <= {1'b0, op_q.caller};
							else
								head_q[op_q.peer] <= {1'b0, op_q.caller};
							tail_q[op_q.peer] <= {1'b0, op_q.caller};
						end
					end else begin
						buf_q[op_q.caller] <= op_q.handle;
						if ((op_q.any && head_q[op_q.caller] != NONE) ||
								(!op_q.any && stat_q[op_q.peer] == ST_SENDING &&
								tgt_q[op_q.peer] == {1'b0, op_q.caller})) begin
							// walk the caller's sender queue to unlink the sender
							s_q <= op_q.any ? head_q[op_q.caller] : {1'b0, op_q.peer};
							prev_q <= NONE;
							cur_q <= head_q[op_q.caller];
							st_q <= S_WALK;
						end else begin
							stat_q[op_q.caller] <= ST_RECEIVING;
							want_q[op_q.caller] <= op_q.any ? ANY : {1'b0, op_q.peer};
						end
					end
				end
				S_WALK: begin
					if (cur_q == s_q || cur_q == NONE) begin
						if (cur_q == s_q) begin
							if (prev_q == NONE) head_q[op_q.caller] <= nxt_q[cur_q[ID_BITS-1:0]];
							else nxt_q[prev_q[ID_BITS-1:0]] <= nxt_q[cur_q[ID_BITS-1:0]];
							if (tail_q[op_q.caller] == s_q) tail_q[op_q.caller] <= prev_q;
						end
						tgt_q[s_q[ID_BITS-1:0]] <= NONE;
						nxt_q[s_q[ID_BITS-1:0]] <= NONE;
						stat_q[s_q[ID_BITS-1:0]] <= ST_NORMAL;
						res_q.outcome <= OUT_DELIVERED;
						res_q.copy_from <= buf_q[s_q[ID_BITS-1:0]];
						res_q.copy_to <= op_q.handle;
						res_q.sender_id <= s_q[ID_BITS-1:0];
						res_q.receiver_id <= op_q.caller;
						res_q.woken_valid <= 1'b1;
						res_q.woken_id <= s_q[ID_BITS-1:0];
						st_q <= S_DONE;
					end else begin
						prev_q <= cur_q;
						cur_q <= nxt_q[cur_q[ID_BITS-1:0]];
					end
				end
				S_DONE: begin
					res_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q)) else $error("state not one-hot");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && !pop |=> res_v_q && $stable(res_q)) else $error("result lost");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DONE |=> res_v_q) else $error("result not posted");
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		res_v_q && res_q.outcome != OUT_DELIVERED |-> !res_q.woken_valid)
		else $error("wake without delivery");
endmodule

// File: rtl/rendezvous_message_ipc.sv
`timescale 1ns / 1ps
// channel   | direction | handshake           | payload
// request   | in        | push / full         | req (req_t)
// result    | out       | empty / pop         | rsp (rsp_t)
//
// a request passes S_EXEC then S_DONE; a receive that finds a waiting sender
// also walks the sender-queue links in S_WALK between them to unlink it
// one result register; next request starts once the result has been taken
// arst_n clears all process states and queues at once, no clearing pass
// a two-entry request queue lets the caller push while the back end works
module rendezvous_message_ipc import rmi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input req_t req,
	output logic empty,
	input logic pop,
	output rsp_t rsp
);
	// transaction between the classifier and the engine
	logic op_valid, op_pop;
	op_t op;

	rmi_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.op_valid(op_valid), .op(op), .op_pop(op_pop)
	);

	rmi_back u_back (
		.clk(clk), .arst_n(arst_n), .op_valid(op_valid), .op(op),
		.op_pop(op_pop), .empty(empty), .pop(pop), .rsp(rsp)
	);
endmodule

// File: tb/rmi_checker.sv
`timescale 1ns / 1ps
module rmi_checker import rmi_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input req_t req,
	input logic empty,
	input logic pop,
	input rsp_t rsp,
	output int fail_count,
	output int pending
);
	localparam int NONE = NUM_PROCS;
	localparam int ANY = NUM_PROCS + 1;

	pstat_t status [NUM_PROCS];
	int wanted [NUM_PROCS];
	int target [NUM_PROCS];
	handle_t buffer [NUM_PROCS];
	int next_link [NUM_PROCS];
	int head [NUM_PROCS];
	int tail [NUM_PROCS];
	rsp_t expected_rsp [$];

	assign pending = expected_rsp.size();

	// remove sender s from owner's queue
	function automatic void unlink(input int owner, input int s);
		int prev;
		int p;
		prev = NONE;
		p = head[owner];
		for (int i = 0; i < NUM_PROCS && p < NUM_PROCS; i++) begin
			if (p == s) begin
				if (prev == NONE) head[owner] = next_link[p];
				else next_link[prev] = next_link[p];
				if (tail[owner] == s) tail[owner] = prev;
				break;
			end
			prev = p;
			p = next_link[p];
		end
		next_link[s] = NONE;
	endfunction

	function automatic void predict_rendezvous(input req_t r);
		rsp_t e;
		int c;
		int d;
		int s;
		e = '0;
		e.outcome = OUT_BLOCKED;
		c = int'(r.caller_id);
		d = int'(r.peer_id);
		if (r.req_type == 1'b0 && c == d) begin
			e.outcome = OUT_ERROR;
		end else if (status[c] != ST_NORMAL) begin
			e.outcome = OUT_BLOCKED;
		end else if (r.req_type == 1'b0) begin
			buffer[c] = r.buffer_handle;
			if (status[d] == ST_RECEIVING && (wanted[d] == c || wanted[d] == ANY)) begin
				e.outcome = OUT_DELIVERED;
				e.copy_from = r.buffer_handle;
				e.copy_to = buffer[d];
				e.sender_id = id_t'(c);
				e.receiver_id = id_t'(d);
				e.woken_valid = 1'b1;
				e.woken_id = id_t'(d);
				wanted[d] = NONE;
				status[d] = ST_NORMAL;
			end else begin
				target[c] = d;
				status[c] = ST_SENDING;
				next_link[c] = NONE;
				if (tail[d] < NUM_PROCS) next_link[tail[d]] = c;
				else head[d] = c;
				tail[d] = c;
			end
		end else begin
			s = NONE;
			buffer[c] = r.buffer_handle;
			if (r.peer_any) begin
				s = head[c];
			end else if (status[d] == ST_SENDING && target[d] == c) begin
				s = d;
			end
			if (s < NUM_PROCS) begin
				unlink(c, s);
				target[s] = NONE;
				next_link[s] = NONE;
				status[s] = ST_NORMAL;
				e.outcome = OUT_DELIVERED;
				e.copy_from = buffer[s];
				e.copy_to = r.buffer_handle;
				e.sender_id = id_t'(s);
				e.receiver_id = id_t'(c);
				e.woken_valid = 1'b1;
				e.woken_id = id_t'(s);
			end else begin
				status[c] = ST_RECEIVING;
				wanted[c] = r.peer_any ? ANY : d;
			end
		end
		expected_rsp.push_back(e);
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		for (int i = 0; i < NUM_PROCS; i++) begin
			status[i] = ST_NORMAL;
			wanted[i] = NONE;
			target[i] = NONE;
			buffer[i] = '0;
			next_link[i] = NONE;
			head[i] = NONE;
			tail[i] = NONE;
		end
	end

	always @(posedge clk) begin
		rsp_t e;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_rsp.size() == 0) begin
					report("unexpected transaction", 64'(rsp.outcome), 64'(0));
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.outcome !== e.outcome)
						report("outcome", 64'(rsp.outcome), 64'(e.outcome));
					if (rsp.copy_from !== e.copy_from)
						report("copy_from", 64'(rsp.copy_from), 64'(e.copy_from));
					if (rsp.copy_to !== e.copy_to)
						report("copy_to", 64'(rsp.copy_to), 64'(e.copy_to));
					if (rsp.sender_id !== e.sender_id)
						report("sender_id", 64'(rsp.sender_id), 64'(e.sender_id));
					if (rsp.receiver_id !== e.receiver_id)
						report("receiver_id", 64'(rsp.receiver_id), 64'(e.receiver_id));
					if (rsp.woken_valid !== e.woken_valid)
						report("woken_valid", 64'(rsp.woken_valid), 64'(e.woken_valid));
					if (rsp.woken_id !== e.woken_id)
						report("woken_id", 64'(rsp.woken_id), 64'(e.woken_id));
				end
			end
			if (push && !full) predict_rendezvous(req);
		end
	end
endmodule

// File: tb/tb_rendezvous_message_ipc.sv
`timescale 1ns / 1ps
module tb_rendezvous_message_ipc;
	import rmi_pkg::*;

	localparam int RANDOM_ITEMS = 1650;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	req_t req = '0;
	logic empty;
	logic pop = 1'b0;
	rsp_t rsp;
	int fail_count;
	int pending;

	// receiver hold-off request from the stimulus side
	bit hold_results = 1'b0;
	int idle_cycles = 0;

	always #5 clk = ~clk;

	rendezvous_message_ipc dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	rmi_checker checker_i (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one transaction and wait until it is taken; push stays high
	task automatic send_req(input logic kind, input id_t caller, input id_t peer,
			input logic any, input handle_t handle);
		req_t r;
		r.req_type = kind;
		r.caller_id = caller;
		r.peer_id = peer;
		r.peer_any = any;
		r.buffer_handle = handle;
		req <= r;
		push <= 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_gapped(input logic kind, input id_t caller, input id_t peer,
			input logic any, input handle_t handle);
		int g;
		g = gap_len();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		send_req(kind, caller, peer, any, handle);
	endtask

	// stop offering and wait until every expected transaction has come
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// rendezvous-shaped random traffic over a small set of processes so that
	// queues form and named receives find their sender mid-queue
	task automatic random_item(input int span);
		logic kind;
		id_t c;
		id_t p;
		logic any;
		handle_t h;
		kind = 1'($urandom_range(0, 1));
		c = id_t'($urandom_range(0, span - 1));
		p = id_t'($urandom_range(0, span - 1));
		if ($urandom_range(0, 9) == 0) p = id_t'($urandom_range(0, NUM_PROCS - 1));
		any = 1'($urandom_range(0, 1));
		h = $urandom;
		send_gapped(kind, c, p, any, h);
	endtask

	// the receiving side, stalled at random and on request
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_results) begin
				pop <= 1'b0;
			end else if (pop && !empty) begin
				g = gap_len();
				if (g > 0) begin
					pop <= 1'b0;
					repeat (g - 1) @(posedge clk);
				end
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no accepted transaction on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: errors, extremes of the fields, simple rendezvous
		send_req(1'b0, 4'd3, 4'd3, 1'b0, 32'hFFFF_FFFF);   // send to self
		send_req(1'b1, 4'd15, 4'd15, 1'b0, 32'h0);         // named receive of self blocks
		send_req(1'b0, 4'd0, 4'd15, 1'b1, 32'hFFFF_FFFF);  // delivers to 15? no, 15 wants 15
		send_req(1'b1, 4'd15, 4'd0, 1'b1, 32'h1234_5678);  // caller not normal
		send_req(1'b1, 4'd1, 4'd0, 1'b1, 32'hAAAA_5555);   // any receive, empty queue
		send_req(1'b0, 4'd2, 4'd1, 1'b0, 32'h5555_AAAA);   // delivers to any receiver
		send_req(1'b0, 4'd4, 4'd5, 1'b0, 32'h0000_0001);   // queue three senders at 5
		send_req(1'b0, 4'd6, 4'd5, 1'b1, 32'h0000_0002);
		send_req(1'b0, 4'd7, 4'd5, 1'b0, 32'h0000_0003);
		send_req(1'b1, 4'd5, 4'd6, 1'b0, 32'h8000_0000);   // named from mid-queue
		send_req(1'b1, 4'd5, 4'd7, 1'b0, 32'h7FFF_FFFF);   // named from tail
		send_req(1'b1, 4'd5, 4'd9, 1'b1, 32'h0F0F_0F0F);   // any takes head
		send_req(1'b1, 4'd5, 4'd9, 1'b0, 32'hF0F0_F0F0);   // named non-sender blocks
		send_req(1'b0, 4'd8, 4'd5, 1'b0, 32'h3333_3333);   // not wanted, queues
		send_req(1'b0, 4'd9, 4'd5, 1'b0, 32'hCCCC_CCCC);   // wanted, delivers
		send_req(1'b1, 4'd5, 4'd8, 1'b0, 32'h1111_1111);
		send_req(1'b0, 4'd14, 4'd0, 1'b0, 32'h2222_2222);  // wakes 0? 15 still waits
		send_req(1'b1, 4'd0, 4'd14, 1'b0, 32'h4444_4444);
		send_req(1'b0, 4'd0, 4'd15, 1'b0, 32'h9999_9999);  // 0 still queued at 15, so blocks
		send_req(1'b1, 4'd10, 4'd11, 1'b0, 32'h6666_6666);
		send_req(1'b0, 4'd11, 4'd10, 1'b0, 32'h7777_7777);

		// sender pauses until every expected transaction has come
		drain();

		// receiver holds off long while the sender keeps offering
		hold_results = 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_results = 1'b0;
			end
			begin
				for (int i = 0; i < 12; i++) send_req(1'($urandom_range(0, 1)),
					id_t'($urandom_range(0, NUM_PROCS - 1)),
					id_t'($urandom_range(0, NUM_PROCS - 1)),
					1'($urandom_range(0, 1)), $urandom);
			end
		join

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 400 == 200) drain();
			random_item((i % 3 == 0) ? NUM_PROCS : $urandom_range(2, 6));
		end

		drain();
		repeat (4 * NUM_PROCS) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/rmi_pkg.sv
rtl/rmi_front.sv
rtl/rmi_back.sv
rtl/rendezvous_message_ipc.sv
tb/rmi_checker.sv
tb/tb_rendezvous_message_ipc.sv
